### rtl/core/dvdd_pkg.sv
// Shared types, constants and lookup functions for the date check and day difference block.
package dvdd_pkg;

  // Field widths.
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int MTERM_W = 9;
  localparam int Q_W     = 8;
  localparam int PROD_W  = 25;
  localparam int DN_W    = 24;
  localparam int DELTA_W = 25;
  localparam int DIFF_W  = 23;

  // Configuration reset values.
  localparam logic [YEAR_W-1:0] YEAR_FLOOR_RST   = 14'd1500;
  localparam logic [YEAR_W-1:0] CURRENT_YEAR_RST = 14'd2024;

  // Division by 25 through a reciprocal: q = (x * 5243) >> 17 is exact for x < 4096.
  localparam logic [PROD_W-1:0] RECIP_25    = 25'd5243;
  localparam int                RECIP_SHIFT = 17;

  // Day number constants.
  localparam logic [DN_W-1:0] DAYS_PER_YEAR = 24'd365;
  localparam logic [DN_W-1:0] EPOCH_OFFSET  = 24'd306;

  // Difference saturation bounds.
  localparam logic signed [DELTA_W-1:0] DIFF_MAX = 25'sd4194303;
  localparam logic signed [DELTA_W-1:0] DIFF_MIN = -25'sd4194303;

  // Configuration register indexes.
  typedef enum logic {
    CFG_YEAR_FLOOR   = 1'b0,
    CFG_CURRENT_YEAR = 1'b1
  } cfg_index_t;

  // Date status codes, first failing check wins.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_YEAR_BAD  = 2'd1,
    STATUS_MONTH_BAD = 2'd2,
    STATUS_DAY_BAD   = 2'd3
  } status_t;

  // Stage one result for one date.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               year_bad;
    logic               ty_neg;
    logic [YEAR_W-1:0]  ty;
    logic [MTERM_W-1:0] mterm;
    logic [PROD_W-1:0]  prod_year;
    logic [PROD_W-1:0]  prod_ty;
  } s1_t;

  // Stage two result for one date.
  typedef struct packed {
    status_t               status;
    logic signed [DN_W-1:0] dn;
  } s2_t;

  // Month length without the leap day; zero for months out of range.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // (153 * tm - 457) / 5 for the shifted month tm of 3 to 15.
  function automatic logic [MTERM_W-1:0] month_term(input logic [MONTH_W-1:0] tm);
    logic [MTERM_W-1:0] t;
    case (tm)
      4'd3:    t = 9'd0;
      4'd4:    t = 9'd31;
      4'd5:    t = 9'd61;
      4'd6:    t = 9'd92;
      4'd7:    t = 9'd122;
      4'd8:    t = 9'd153;
      4'd9:    t = 9'd184;
      4'd10:   t = 9'd214;
      4'd11:   t = 9'd245;
      4'd12:   t = 9'd275;
      4'd13:   t = 9'd306;
      4'd14:   t = 9'd337;
      4'd15:   t = 9'd367;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

endpackage

### rtl/core/dvdd_front.sv
// Stage one for one date: year range check, month shift and reciprocal products.
module dvdd_front
  import dvdd_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [YEAR_W-1:0]   year,
  input  logic [MONTH_W-1:0]  month,
  input  logic [DAY_W-1:0]    day,
  input  logic [YEAR_W-1:0]   year_floor,
  input  logic [YEAR_W-1:0]   current_year,
  output s1_t                 s1
);

  logic                 early;
  logic                 ty_neg_next;
  logic [YEAR_W-1:0]    ty_next;
  logic [MONTH_W-1:0]   tm;
  logic [YEAR_W:0]      year_top;
  logic                 year_bad_next;

  // January and February count as months 13 and 14 of the previous year.
  assign early       = (month < 4'd3);
  assign ty_neg_next = early && (year == '0);
  assign ty_next     = (early && !ty_neg_next) ? (year - 14'd1) : (ty_neg_next ? '0 : year);
  assign tm          = early ? (month + 4'd12) : month;

  // Year must lie from year_floor to current_year + 1.
  assign year_top      = {1'b0, current_year} + 15'd1;
  assign year_bad_next = (year < year_floor) || ({1'b0, year} > year_top);

  // Stage register; the products give quotients by 100 after the shift.
  always_ff @(posedge clk) begin
    if (en) begin
      s1.year      <= year;
      s1.month     <= month;
      s1.day       <= day;
      s1.year_bad  <= year_bad_next;
      s1.ty_neg    <= ty_neg_next;
      s1.ty        <= ty_next;
      s1.mterm     <= month_term(tm);
      s1.prod_year <= {13'd0, year[YEAR_W-1:2]} * RECIP_25;
      s1.prod_ty   <= {13'd0, ty_next[YEAR_W-1:2]} * RECIP_25;
    end
  end

endmodule

### rtl/core/dvdd_daynum.sv
// Stage two for one date: leap rule, date status and Rata Die day number.
module dvdd_daynum
  import dvdd_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  s1_t  s1,
  output s2_t  s2
);

  logic [Q_W-1:0]    q100_year;
  logic [Q_W-1:0]    q100_ty;
  logic [Q_W-1:0]    q400_ty;
  logic              cent;
  logic              leap;
  logic [DAY_W-1:0]  len;
  status_t           status_next;
  logic [DN_W-1:0]   dn_next;

  // Quotients by 100 and 400 from the registered reciprocal products.
  assign q100_year = s1.prod_year[RECIP_SHIFT +: Q_W];
  assign q100_ty   = s1.prod_ty[RECIP_SHIFT +: Q_W];
  assign q400_ty   = {2'd0, q100_ty[Q_W-1:2]};

  // Leap year: divisible by 4 and not by 100, or divisible by 400.
  assign cent = (s1.year == ({6'd0, q100_year} * 14'd100));
  assign leap = ((s1.year[1:0] == 2'd0) && !cent) || (cent && (q100_year[1:0] == 2'd0));
  assign len  = month_len(s1.month) + {4'd0, (s1.month == 4'd2) && leap};

  // Status with year first, then month, then day.
  always_comb begin
    if (s1.year_bad) begin
      status_next = STATUS_YEAR_BAD;
    end else if ((s1.month < 4'd1) || (s1.month > 4'd12)) begin
      status_next = STATUS_MONTH_BAD;
    end else if ((s1.day < 5'd1) || (s1.day > len)) begin
      status_next = STATUS_DAY_BAD;
    end else begin
      status_next = STATUS_OK;
    end
  end

  // Day number in two's complement; a year before year one adds -365 only.
  assign dn_next = ({10'd0, s1.ty} * DAYS_PER_YEAR)
                 + {12'd0, s1.ty[YEAR_W-1:2]}
                 - {16'd0, q100_ty}
                 + {16'd0, q400_ty}
                 + {15'd0, s1.mterm}
                 + {19'd0, s1.day}
                 - EPOCH_OFFSET
                 - (s1.ty_neg ? DAYS_PER_YEAR : '0);

  // Stage register.
  always_ff @(posedge clk) begin
    if (en) begin
      s2.status <= status_next;
      s2.dn     <= $signed(dn_next);
    end
  end

endmodule

### rtl/core/dvdd_compare.sv
// Stage three: day difference with saturation and the order flags.
module dvdd_compare
  import dvdd_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  s2_t                      s2_a,
  input  s2_t                      s2_b,
  output logic [1:0]               status_a,
  output logic [1:0]               status_b,
  output logic signed [DIFF_W-1:0] day_difference,
  output logic                     is_less,
  output logic                     is_equal,
  output logic                     is_greater
);

  logic signed [DELTA_W-1:0] delta;
  logic signed [DELTA_W-1:0] clipped;

  // Full width difference, then clip to the output range.
  assign delta = DELTA_W'(s2_a.dn) - DELTA_W'(s2_b.dn);

  always_comb begin
    if (delta > DIFF_MAX) begin
      clipped = DIFF_MAX;
    end else if (delta < DIFF_MIN) begin
      clipped = DIFF_MIN;
    end else begin
      clipped = delta;
    end
  end

  // Output register; flags follow the unclipped comparison.
  always_ff @(posedge clk) begin
    if (en) begin
      status_a       <= s2_a.status;
      status_b       <= s2_b.status;
      day_difference <= clipped[DIFF_W-1:0];
      is_less        <= (s2_a.dn < s2_b.dn);
      is_equal       <= (s2_a.dn == s2_b.dn);
      is_greater     <= (s2_a.dn > s2_b.dn);
    end
  end

endmodule

### rtl/core/date_validate_and_day_difference_top.sv
// Top level of the date check and day difference pipeline.
//
//   Channel   Handshake                 Payload
//   input     in_valid / in_ready       year_a month_a day_a year_b month_b day_b
//   output    out_valid / out_ready     status_a status_b day_difference is_less
//                                       is_equal is_greater
//   config    cfg_we                    cfg_index cfg_data
//
// Three register stages: range check and reciprocal products, day numbers and
// status, then difference and flags. One item is accepted every cycle unless a
// stall reaches the input. Each stage advances when it is empty or the next one
// advances, so a stall on out_ready holds all items in place and bubbles fill.
// Reset clears the stage valid bits and loads year_floor 1500, current_year 2024.
module date_validate_and_day_difference_top
  import dvdd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [YEAR_W-1:0]        year_a,
  input  logic [MONTH_W-1:0]       month_a,
  input  logic [DAY_W-1:0]         day_a,
  input  logic [YEAR_W-1:0]        year_b,
  input  logic [MONTH_W-1:0]       month_b,
  input  logic [DAY_W-1:0]         day_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status_a,
  output logic [1:0]               status_b,
  output logic signed [DIFF_W-1:0] day_difference,
  output logic                     is_less,
  output logic                     is_equal,
  output logic                     is_greater,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [YEAR_W-1:0]        cfg_data
);

  logic [YEAR_W-1:0] year_floor;
  logic [YEAR_W-1:0] current_year;
  logic              v1;
  logic              v2;
  logic              v3;
  logic              en1;
  logic              en2;
  logic              en3;
  s1_t               s1_a;
  s1_t               s1_b;
  s2_t               s2_a;
  s2_t               s2_b;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      year_floor   <= YEAR_FLOOR_RST;
      current_year <= CURRENT_YEAR_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_YEAR_FLOOR:   year_floor   <= cfg_data;
        CFG_CURRENT_YEAR: current_year <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when its contents move on.
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v3;

  // Valid bits that travel with each item.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  // Stage one for both dates.
  dvdd_front u_front_a (
    .clk          (clk),
    .en           (en1),
    .year         (year_a),
    .month        (month_a),
    .day          (day_a),
    .year_floor   (year_floor),
    .current_year (current_year),
    .s1           (s1_a)
  );

  dvdd_front u_front_b (
    .clk          (clk),
    .en           (en1),
    .year         (year_b),
    .month        (month_b),
    .day          (day_b),
    .year_floor   (year_floor),
    .current_year (current_year),
    .s1           (s1_b)
  );

  // Stage two for both dates.
  dvdd_daynum u_daynum_a (
    .clk (clk),
    .en  (en2),
    .s1  (s1_a),
    .s2  (s2_a)
  );

  dvdd_daynum u_daynum_b (
    .clk (clk),
    .en  (en2),
    .s1  (s1_b),
    .s2  (s2_b)
  );

  // Stage three and the output register.
  dvdd_compare u_compare (
    .clk            (clk),
    .en             (en3),
    .s2_a           (s2_a),
    .s2_b           (s2_b),
    .status_a       (status_a),
    .status_b       (status_b),
    .day_difference (day_difference),
    .is_less        (is_less),
    .is_equal       (is_equal),
    .is_greater     (is_greater)
  );

endmodule

### dv/tb_date_validate_and_day_difference_top.sv
// Self-checking testbench for the date check and day difference pipeline.
`timescale 1ns / 100ps

module tb_date_validate_and_day_difference_top
  import dvdd_pkg::*;
();

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int PIPE_LATENCY  = 3;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 230;
  localparam int PHASE_COUNT   = 6;
  localparam longint GAP_LIMIT = 4194303;

  // One calendar date as it appears on the input ports.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // One result item: two statuses, the day gap and the ordering flags.
  typedef struct packed {
    status_t                  status_a;
    status_t                  status_b;
    logic signed [DIFF_W-1:0] difference;
    logic                     less;
    logic                     equal;
    logic                     greater;
  } gap_result_t;

  // Predicts the result of each accepted date pair and checks the results in order.
  class day_gap_board;
    int unsigned year_floor;
    int unsigned current_year;
    gap_result_t expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned less_hits;
    int unsigned equal_hits;
    int unsigned greater_hits;

    function new();
      year_floor   = YEAR_FLOOR_RST;
      current_year = CURRENT_YEAR_RST;
      errors       = 0;
      checked      = 0;
      less_hits    = 0;
      equal_hits   = 0;
      greater_hits = 0;
    endfunction

    static function bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Days in month m of year y, zero when the month is out of range.
    static function int month_span(int y, int m);
      int len;
      case (m)
        1, 3, 5, 7, 8, 10, 12: len = 31;
        4, 6, 9, 11:           len = 30;
        2:                     len = leap_year(y) ? 29 : 28;
        default:               len = 0;
      endcase
      return len;
    endfunction

    // Year first, then month, then day; the first failing check wins.
    function status_t date_verdict(date_t d);
      int y;
      int m;
      int dd;
      y  = d.year;
      m  = d.month;
      dd = d.day;
      if (y < int'(year_floor) || y > int'(current_year) + 1) return STATUS_YEAR_BAD;
      if (m < 1 || m > 12) return STATUS_MONTH_BAD;
      if (dd < 1 || dd > month_span(y, m)) return STATUS_DAY_BAD;
      return STATUS_OK;
    endfunction

    // Day count from the raw fields, with January and February moved to the prior year.
    static function longint day_count(date_t d);
      longint ty;
      longint tm;
      longint dd;
      ty = d.year;
      tm = d.month;
      dd = d.day;
      if (tm < 3) begin
        ty = ty - 1;
        tm = tm + 12;
      end
      return 365 * ty + ty / 4 - ty / 100 + ty / 400 + (153 * tm - 457) / 5 + dd - 306;
    endfunction

    function void note_dates(date_t a, date_t b);
      gap_result_t r;
      longint na;
      longint nb;
      longint gap;
      na  = day_count(a);
      nb  = day_count(b);
      gap = na - nb;
      if (gap > GAP_LIMIT) gap = GAP_LIMIT;
      if (gap < -GAP_LIMIT) gap = -GAP_LIMIT;
      r.status_a   = date_verdict(a);
      r.status_b   = date_verdict(b);
      r.difference = gap[DIFF_W-1:0];
      r.less       = (na < nb);
      r.equal      = (na == nb);
      r.greater    = (na > nb);
      expected_q.push_back(r);
    endfunction

    function void check_gap(gap_result_t got);
      gap_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result item arrived with no date pair outstanding");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (exp_r.less) less_hits++;
      if (exp_r.equal) equal_hits++;
      if (exp_r.greater) greater_hits++;
      if (got.status_a !== exp_r.status_a) begin
        $error("status_a expected %0d got %0d", exp_r.status_a, got.status_a);
        errors++;
      end
      if (got.status_b !== exp_r.status_b) begin
        $error("status_b expected %0d got %0d", exp_r.status_b, got.status_b);
        errors++;
      end
      if (got.difference !== exp_r.difference) begin
        $error("day_difference expected %0d got %0d", exp_r.difference, got.difference);
        errors++;
      end
      if (got.less !== exp_r.less) begin
        $error("is_less expected %0d got %0d", exp_r.less, got.less);
        errors++;
      end
      if (got.equal !== exp_r.equal) begin
        $error("is_equal expected %0d got %0d", exp_r.equal, got.equal);
        errors++;
      end
      if (got.greater !== exp_r.greater) begin
        $error("is_greater expected %0d got %0d", exp_r.greater, got.greater);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [YEAR_W-1:0]        year_a;
  logic [MONTH_W-1:0]       month_a;
  logic [DAY_W-1:0]         day_a;
  logic [YEAR_W-1:0]        year_b;
  logic [MONTH_W-1:0]       month_b;
  logic [DAY_W-1:0]         day_b;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               status_a;
  logic [1:0]               status_b;
  logic signed [DIFF_W-1:0] day_difference;
  logic                     is_less;
  logic                     is_equal;
  logic                     is_greater;
  logic                     cfg_we;
  cfg_index_t               cfg_index;
  logic [YEAR_W-1:0]        cfg_data;

  day_gap_board board;
  int src_idle_pct = 20;
  int dst_idle_pct = 84;
  int pairs_sent = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  date_validate_and_day_difference_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .year_a         (year_a),
    .month_a        (month_a),
    .day_a          (day_a),
    .year_b         (year_b),
    .month_b        (month_b),
    .day_b          (day_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status_a       (status_a),
    .status_b       (status_b),
    .day_difference (day_difference),
    .is_less        (is_less),
    .is_equal       (is_equal),
    .is_greater     (is_greater),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic date_t mk(int y, int m, int d);
    date_t r;
    r.year  = YEAR_W'(y);
    r.month = MONTH_W'(m);
    r.day   = DAY_W'(d);
    return r;
  endfunction

  // Random date, mostly well formed and near the current valid year window.
  function automatic date_t random_date();
    int y;
    int m;
    int len;
    int r;
    int y_lo;
    r = $urandom_range(99);
    if (r < 50) begin
      // Keep the lower bound positive so the draw stays near the window.
      y_lo = int'(board.year_floor) - 2;
      if (y_lo < 1) y_lo = 1;
      y = $urandom_range(y_lo, int'(board.current_year) + 3);
      if (y < 1) y = 1;
      if (y > 9999) y = 9999;
    end else if (r < 65) begin
      case ($urandom_range(9))
        0: y = 1;
        1: y = 4;
        2: y = 100;
        3: y = 400;
        4: y = 1600;
        5: y = 1900;
        6: y = 2000;
        7: y = 2100;
        8: y = 9996;
        default: y = 9999;
      endcase
    end else begin
      y = $urandom_range(1, 9999);
    end
    m   = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(0, 15);
    len = day_gap_board::month_span(y, m);
    r   = $urandom_range(99);
    if (r < 70 && len > 0) return mk(y, m, $urandom_range(1, len));
    if (r < 80) return mk(y, m, len + $urandom_range(1));
    return mk(y, m, $urandom_range(0, 31));
  endfunction

  // Present one date pair and hold it until the block takes it.
  task automatic push_pair(input date_t a, input date_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    year_a   = a.year;
    month_a  = a.month;
    day_a    = a.day;
    year_b   = b.year;
    month_b  = b.month;
    day_b    = b.day;
    do @(posedge clk); while (!in_ready);
    board.note_dates(a, b);
    pairs_sent++;
    @(negedge clk);
  endtask

  // Wait for every outstanding result, then let the pipeline empty.
  task automatic drain_results();
    in_valid = 1'b0;
    while (board.expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // Load both year registers on consecutive cycles while the block is idle.
  task automatic write_years(input int lo, input int hi);
    cfg_we    = 1'b1;
    cfg_index = CFG_YEAR_FLOOR;
    cfg_data  = YEAR_W'(lo);
    @(posedge clk);
    board.year_floor = lo;
    @(negedge clk);
    cfg_index = CFG_CURRENT_YEAR;
    cfg_data  = YEAR_W'(hi);
    @(posedge clk);
    board.current_year = hi;
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // Receiver: back-pressure drawn fresh every cycle.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Result checking and the stall watchdog.
  initial begin
    gap_result_t got;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && out_ready) begin
          got.status_a   = status_t'(status_a);
          got.status_b   = status_t'(status_b);
          got.difference = day_difference;
          got.less       = is_less;
          got.equal      = is_equal;
          got.greater    = is_greater;
          board.check_gap(got);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Main sequence: reset, directed pairs, then random phases over several settings.
  initial begin
    int lo;
    int hi;
    date_t a;
    date_t b;
    board     = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    year_a    = '0;
    month_a   = '0;
    day_a     = '0;
    year_b    = '0;
    month_b   = '0;
    day_b     = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_YEAR_FLOOR;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed pairs under the reset year window of 1500 to 2025.
    push_pair(mk(2024, 2, 29), mk(2024, 2, 29));
    push_pair(mk(2023, 2, 29), mk(2023, 3, 1));
    push_pair(mk(1900, 2, 29), mk(2000, 2, 29));
    push_pair(mk(1700, 2, 29), mk(1600, 2, 29));
    push_pair(mk(1499, 6, 15), mk(1500, 1, 1));
    push_pair(mk(2025, 12, 31), mk(2026, 1, 1));
    push_pair(mk(2000, 0, 10), mk(2000, 13, 10));
    push_pair(mk(2000, 15, 31), mk(2000, 12, 31));
    push_pair(mk(2000, 1, 0), mk(2000, 4, 31));
    push_pair(mk(2000, 4, 30), mk(2000, 1, 31));
    push_pair(mk(1, 1, 1), mk(9999, 12, 31));
    push_pair(mk(9999, 12, 31), mk(1, 1, 1));
    // Year zero pushed back to year minus one by the January shift.
    push_pair(mk(0, 0, 0), mk(0, 2, 31));
    // Gaps too large for the output saturate, flags still follow the true order.
    push_pair(mk(16383, 15, 31), mk(0, 1, 0));
    push_pair(mk(0, 1, 0), mk(16383, 15, 31));
    push_pair(mk(16383, 0, 0), mk(1, 1, 1));
    push_pair(mk(2020, 3, 1), mk(2020, 2, 29));
    // An invalid date can still land on the same day as a valid one.
    push_pair(mk(2024, 11, 31), mk(2024, 12, 1));
    push_pair(mk(1500, 1, 1), mk(2025, 12, 31));
    push_pair(mk(2021, 2, 28), mk(2021, 2, 28));

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_results();
      // Two phases per back-pressure pattern.
      case (ph / 2)
        0: begin
          src_idle_pct = 20;
          dst_idle_pct = 84;
        end
        1: begin
          src_idle_pct = 84;
          dst_idle_pct = 20;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      case (ph)
        0: begin
          lo = 1;
          hi = 9998;
        end
        1: begin
          lo = 9999;
          hi = 9998;
        end
        2: begin
          lo = 1;
          hi = 1;
        end
        3: begin
          lo = 1582;
          hi = 2100;
        end
        4: begin
          lo = 2000;
          hi = 1000;
        end
        default: begin
          lo = $urandom_range(1, 5000);
          hi = $urandom_range(lo, 9998);
        end
      endcase
      write_years(lo, hi);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        a = random_date();
        case ($urandom_range(9))
          0: b = a;
          1, 2: begin
            // Near neighbor of the first date.
            b = a;
            case ($urandom_range(3))
              0: b.day = a.day + 5'd1;
              1: b.day = a.day - 5'd1;
              2: if (a.year < 9999) b.year = a.year + 14'd1;
              default: b.month = a.month + 4'd1;
            endcase
          end
          default: b = random_date();
        endcase
        push_pair(a, b);
      end
    end

    drain_results();
    if (board.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", board.expected_q.size());
      board.errors++;
    end
    $display("Sent %0d date pairs under %0d year windows, %0d results checked.",
             pairs_sent, settings_used, board.checked);
    $display("Ordering seen: %0d before, %0d same day, %0d after.",
             board.less_hits, board.equal_hits, board.greater_hits);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
